// ===== sv/lms_pkg.sv =====
// Shared types, timing constants and register indexes for the LCD mode/line sequencer.
`default_nettype none

package lms_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 8;
    localparam int OUT_DATA_W     = 32;

    // Mode durations in clocks
    localparam int unsigned T_HBLANK  = 204;
    localparam int unsigned T_VLINE   = 456;
    localparam int unsigned T_VBLANK  = 4560;
    localparam int unsigned T_OAM     = 80;
    localparam int unsigned T_XFER    = 172;
    localparam int unsigned T_REFRESH = 16384;

    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAYER_ENABLES  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STAT_IRQ_EN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COMPARE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_Y       = 3'd4;

    // Mode codes as seen on the result
    localparam logic [1:0] LCD_MODE_HBLANK = 2'd0;
    localparam logic [1:0] LCD_MODE_VBLANK = 2'd1;
    localparam logic [1:0] LCD_MODE_OAM    = 2'd2;
    localparam logic [1:0] LCD_MODE_XFER   = 2'd3;

    // STAT enable bits
    localparam int STAT_EN_HBLANK = 0;
    localparam int STAT_EN_VBLANK = 1;
    localparam int STAT_EN_OAM    = 2;
    localparam int STAT_EN_LYC    = 3;

    // Layer enable bits
    localparam int LAYER_BG     = 0;
    localparam int LAYER_WINDOW = 1;
    localparam int LAYER_SPRITE = 2;

    typedef enum logic [3:0] {
        MODE_HBLANK = 4'b0001,
        MODE_VBLANK = 4'b0010,
        MODE_OAM    = 4'b0100,
        MODE_XFER   = 4'b1000
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] line;
        logic       powering_on;
        logic       coincidence;
    } t_ctl;

    typedef struct packed {
        logic       display_enable;
        logic [2:0] layer_enables;
        logic [3:0] stat_irq_enables;
        logic [7:0] line_compare;
        logic [7:0] scroll_y;
    } t_cfg;

    typedef struct packed {
        logic [1:0] obj_window_line_draw;
        logic [7:0] bg_line_index;
        logic       bg_line_draw;
        logic       poll_request;
        logic       frame_draw;
        logic       stat_irq;
        logic       vblank_irq;
        logic       coincidence;
        logic [7:0] current_line;
        logic [1:0] lcd_mode;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] code;
        case (m)
            MODE_HBLANK: code = LCD_MODE_HBLANK;
            MODE_VBLANK: code = LCD_MODE_VBLANK;
            MODE_OAM:    code = LCD_MODE_OAM;
            MODE_XFER:   code = LCD_MODE_XFER;
            default:     code = LCD_MODE_VBLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lcd_mode_line_sequencer_top.sv =====
// LCD mode/line sequencer: timestamp stream in, mode/line/request stream out.
// Result path: input register, then result register.
// Throughput: one timestamp per cycle while the result stream is not stalled; the state
//   update is done in the cycle a timestamp moves from the input to the result register.
// Reset (synchronous, active low): mode V-blank, line 0, powering-on set, times and
//   configuration cleared, both stages empty.
`default_nettype none

module lcd_mode_line_sequencer_top #(
    parameter int TIME_WIDTH = lms_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [lms_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [lms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // timestamp stream
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: cpu_clock[TIME_WIDTH-1:0], zero fill up to whole bytes
    input  wire logic [((TIME_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    // result stream
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: lcd_mode[1:0], current_line[9:2], coincidence[10], vblank_irq[11],
    //   stat_irq[12], frame_draw[13], poll_request[14], bg_line_draw[15],
    //   bg_line_index[23:16], obj_window_line_draw[25:24], zeros[31:26]
    output logic [lms_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata
);

    logic                  r_in_valid;
    logic [TIME_WIDTH-1:0] r_in_time;

    lms_pkg::t_ctl         r_ctl;
    lms_pkg::t_ctl         n_ctl;
    logic [TIME_WIDTH-1:0] r_line_start;
    logic [TIME_WIDTH-1:0] n_line_start;
    logic [TIME_WIDTH-1:0] r_refresh;
    logic [TIME_WIDTH-1:0] n_refresh;
    logic [TIME_WIDTH-1:0] r_vb_start;
    logic [TIME_WIDTH-1:0] n_vb_start;

    lms_pkg::t_cfg         r_cfg;
    lms_pkg::t_result      n_res;

    logic                  r_out_valid;
    logic [lms_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                  advance;

    // move the held request into the result register when that slot frees up
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lms_pkg::CFG_DISPLAY_ENABLE: r_cfg.display_enable   <= i_cfg_data[0];
                lms_pkg::CFG_LAYER_ENABLES:  r_cfg.layer_enables    <= i_cfg_data[2:0];
                lms_pkg::CFG_STAT_IRQ_EN:    r_cfg.stat_irq_enables <= i_cfg_data[3:0];
                lms_pkg::CFG_LINE_COMPARE:   r_cfg.line_compare     <= i_cfg_data;
                lms_pkg::CFG_SCROLL_Y:       r_cfg.scroll_y         <= i_cfg_data;
                default:                     r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_time <= i_s_axis_tdata[TIME_WIDTH-1:0];
        end
    end

    lms_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_time       (r_in_time),
        .i_ctl        (r_ctl),
        .i_line_start (r_line_start),
        .i_refresh    (r_refresh),
        .i_vb_start   (r_vb_start),
        .i_cfg        (r_cfg),
        .o_ctl        (n_ctl),
        .o_line_start (n_line_start),
        .o_refresh    (n_refresh),
        .o_vb_start   (n_vb_start),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.mode        <= lms_pkg::MODE_VBLANK;
            r_ctl.line        <= 8'd0;
            r_ctl.powering_on <= 1'b1;
            r_ctl.coincidence <= 1'b0;
            r_line_start      <= '0;
            r_refresh         <= '0;
            r_vb_start        <= '0;
        end else if (advance) begin
            r_ctl        <= n_ctl;
            r_line_start <= n_line_start;
            r_refresh    <= n_refresh;
            r_vb_start   <= n_vb_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {{(lms_pkg::OUT_DATA_W - $bits(lms_pkg::t_result)){1'b0}}, n_res};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a frame request is only made on V-blank entry, together with poll and V-blank irq
    a_frame_on_vblank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[13]) |->
        (o_m_axis_tdata[14] && o_m_axis_tdata[11]
         && (o_m_axis_tdata[1:0] == lms_pkg::LCD_MODE_VBLANK)))
        else $error("frame request outside V-blank entry");

    a_bg_draw_in_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[15]) |->
        (o_m_axis_tdata[1:0] == lms_pkg::LCD_MODE_XFER))
        else $error("background line request outside pixel transfer");

    a_obj_draw_in_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[25:24] != 2'b00)) |->
        (o_m_axis_tdata[1:0] == lms_pkg::LCD_MODE_HBLANK))
        else $error("sprite/window line request outside H-blank");

    // visible modes never run on a V-blank line
    a_visible_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.mode != lms_pkg::MODE_VBLANK) |-> (r_ctl.line < lms_pkg::FIRST_VBLANK_LINE))
        else $error("visible mode on V-blank line");
`endif

endmodule

`default_nettype wire

// ===== sv/lms_step.sv =====
// Next-state and result logic for one timestamp of the LCD mode/line sequencer.
`default_nettype none

module lms_step #(
    parameter int TIME_WIDTH = lms_pkg::TIME_WIDTH_DEF
) (
    input  wire logic [TIME_WIDTH-1:0] i_time,
    input  wire lms_pkg::t_ctl         i_ctl,
    input  wire logic [TIME_WIDTH-1:0] i_line_start,
    input  wire logic [TIME_WIDTH-1:0] i_refresh,
    input  wire logic [TIME_WIDTH-1:0] i_vb_start,
    input  wire lms_pkg::t_cfg         i_cfg,
    output lms_pkg::t_ctl              o_ctl,
    output logic [TIME_WIDTH-1:0]      o_line_start,
    output logic [TIME_WIDTH-1:0]      o_refresh,
    output logic [TIME_WIDTH-1:0]      o_vb_start,
    output lms_pkg::t_result           o_res
);

    localparam logic [TIME_WIDTH-1:0] HBLANK_LEN  = TIME_WIDTH'(lms_pkg::T_HBLANK);
    localparam logic [TIME_WIDTH-1:0] VLINE_LEN   = TIME_WIDTH'(lms_pkg::T_VLINE);
    localparam logic [TIME_WIDTH-1:0] VBLANK_LEN  = TIME_WIDTH'(lms_pkg::T_VBLANK);
    localparam logic [TIME_WIDTH-1:0] OAM_LEN     = TIME_WIDTH'(lms_pkg::T_OAM);
    localparam logic [TIME_WIDTH-1:0] XFER_LEN    = TIME_WIDTH'(lms_pkg::T_XFER);
    localparam logic [TIME_WIDTH-1:0] REFRESH_LEN = TIME_WIDTH'(lms_pkg::T_REFRESH);

    logic [TIME_WIDTH-1:0] d_line;
    logic [TIME_WIDTH-1:0] d_vblank;
    logic [TIME_WIDTH-1:0] d_refresh;
    logic [7:0]            line_inc;

    assign d_line    = i_time - i_line_start;
    assign d_vblank  = i_time - i_vb_start;
    assign d_refresh = i_time - i_refresh;
    assign line_inc  = i_ctl.line + 8'd1;

    always_comb begin
        o_ctl        = i_ctl;
        o_line_start = i_line_start;
        o_refresh    = i_refresh;
        o_vb_start   = i_vb_start;
        o_res        = '0;

        case (i_ctl.mode)
            lms_pkg::MODE_HBLANK: begin
                if (d_line >= HBLANK_LEN) begin
                    o_ctl.line   = line_inc;
                    o_line_start = i_time;
                    if (line_inc >= lms_pkg::FIRST_VBLANK_LINE) begin
                        o_ctl.mode     = lms_pkg::MODE_VBLANK;
                        o_vb_start     = i_time;
                        o_refresh      = i_time;
                        o_res.stat_irq = i_cfg.stat_irq_enables[lms_pkg::STAT_EN_VBLANK];
                        o_res.vblank_irq = i_cfg.display_enable;
                        // frame and poll only once a full refresh period has passed
                        if (d_refresh >= REFRESH_LEN) begin
                            o_res.frame_draw   = i_cfg.display_enable;
                            o_res.poll_request = 1'b1;
                        end
                    end else begin
                        o_ctl.mode     = lms_pkg::MODE_OAM;
                        o_res.stat_irq = i_cfg.stat_irq_enables[lms_pkg::STAT_EN_OAM];
                    end
                end
            end
            lms_pkg::MODE_VBLANK: begin
                if (d_line >= VLINE_LEN) begin
                    if (!i_ctl.powering_on) begin
                        o_ctl.line = line_inc;
                    end
                    o_line_start = i_time;
                end
                // timeout wins over a line tick in the same step
                if (d_vblank >= VBLANK_LEN) begin
                    o_ctl.mode        = lms_pkg::MODE_OAM;
                    o_ctl.line        = 8'd0;
                    o_ctl.powering_on = 1'b0;
                    o_line_start      = i_time;
                    o_res.stat_irq    = i_cfg.stat_irq_enables[lms_pkg::STAT_EN_OAM];
                end
            end
            lms_pkg::MODE_OAM: begin
                if (d_line >= OAM_LEN) begin
                    o_ctl.mode         = lms_pkg::MODE_XFER;
                    o_line_start       = i_time;
                    o_res.bg_line_draw = i_cfg.display_enable
                                         & i_cfg.layer_enables[lms_pkg::LAYER_BG];
                end
            end
            lms_pkg::MODE_XFER: begin
                if (d_line >= XFER_LEN) begin
                    o_ctl.mode     = lms_pkg::MODE_HBLANK;
                    o_line_start   = i_time;
                    o_res.stat_irq = i_cfg.stat_irq_enables[lms_pkg::STAT_EN_HBLANK];
                    o_res.obj_window_line_draw[0] = i_cfg.display_enable
                        & i_cfg.layer_enables[lms_pkg::LAYER_SPRITE];
                    o_res.obj_window_line_draw[1] = i_cfg.display_enable
                        & i_cfg.layer_enables[lms_pkg::LAYER_WINDOW];
                end
            end
            default: begin
                o_ctl.mode = i_ctl.mode;
            end
        endcase

        // re-evaluate coincidence only on a line change
        if (o_ctl.line != i_ctl.line) begin
            if (i_cfg.display_enable && (o_ctl.line == i_cfg.line_compare)) begin
                o_ctl.coincidence = 1'b1;
                if (i_cfg.stat_irq_enables[lms_pkg::STAT_EN_LYC]) begin
                    o_res.stat_irq = 1'b1;
                end
            end else begin
                o_ctl.coincidence = 1'b0;
            end
        end

        o_res.lcd_mode      = lms_pkg::mode_code(o_ctl.mode);
        o_res.current_line  = o_ctl.line;
        o_res.coincidence   = o_ctl.coincidence;
        o_res.bg_line_index = i_cfg.scroll_y + o_ctl.line;
    end

endmodule

`default_nettype wire
